>>> rtl/core/arls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package arls_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int SAMPLE_W    = 10;
    localparam int LEVEL_W     = SAMPLE_BITS;
    localparam int PCT_W       = 7;
    localparam int HOLD_W      = 8;
    localparam int NUM_W       = LEVEL_W + PCT_W;
    localparam int STEP_W      = $clog2(PCT_W);
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD      = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_INIT_MIN  = CFG_INDEX_W'(2);

    localparam logic [PCT_W-1:0]   PERCENT_FULL    = PCT_W'(100);
    localparam logic [PCT_W-1:0]   THRESHOLD_RESET = PCT_W'(80);
    localparam logic [HOLD_W-1:0]  HOLD_RESET      = HOLD_W'(10);
    localparam logic [LEVEL_W-1:0] LEVEL_RESET     = LEVEL_W'(100);

    localparam logic ACTION_CALIBRATE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIDEN,
        ST_SCALE,
        ST_DIVIDE,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   num;
        logic [LEVEL_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [LEVEL_W-1:0] to_level(input logic [SAMPLE_W-1:0] v);
        logic [LEVEL_W-1:0] r;
        r = '0;
        for (int i = 0; i < LEVEL_W; i++)
        begin
            if (i < SAMPLE_W)
            begin
                r[i] = v[i];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/arls_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface arls_in_if;
    logic                               valid;
    logic                               ready;
    logic                               action;
    logic [arls_pkg::SAMPLE_W-1:0]      sample;

    modport source (output valid, output action, output sample, input ready);
    modport sink   (input valid, input action, input sample, output ready);
endinterface

interface arls_out_if;
    logic                               valid;
    logic                               ready;
    logic                               relay_on;
    logic [arls_pkg::PCT_W-1:0]         light_percent;
    logic                               range_zero;

    modport source (output valid, output relay_on, output light_percent,
                    output range_zero, input ready);
    modport sink   (input valid, input relay_on, input light_percent,
                    input range_zero, output ready);
endinterface

interface arls_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [arls_pkg::CFG_INDEX_W-1:0]   index;
    logic [arls_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/arls_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module arls_divider (
    input  wire                 clk,
    input  wire                 rst_n,
    input  arls_pkg::div_req_t  req,
    output arls_pkg::div_rsp_t  rsp
);

    logic [arls_pkg::NUM_W-1:0]  rem_reg;
    logic [arls_pkg::NUM_W-1:0]  rem_next;
    logic [arls_pkg::NUM_W-1:0]  den_reg;
    logic [arls_pkg::NUM_W-1:0]  den_next;
    logic [arls_pkg::PCT_W-1:0]  quo_reg;
    logic [arls_pkg::PCT_W-1:0]  quo_next;
    logic [arls_pkg::STEP_W-1:0] step_reg;
    logic [arls_pkg::STEP_W-1:0] step_next;
    logic                        busy_reg;
    logic                        busy_next;
    logic                        done_reg;
    logic                        done_next;
    logic [arls_pkg::NUM_W:0]    diff;
    logic                        fits;

    assign diff = {1'b0, rem_reg} - {1'b0, den_reg};
    assign fits = ~diff[arls_pkg::NUM_W];

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.num;
            den_next  = arls_pkg::NUM_W'(req.den) << (arls_pkg::PCT_W - 1);
            quo_next  = '0;
            step_next = arls_pkg::STEP_W'(arls_pkg::PCT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = diff[arls_pkg::NUM_W-1:0];
            end
            quo_next = {quo_reg[arls_pkg::PCT_W-2:0], fits};
            den_next = den_reg >> 1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

>>> rtl/core/auto_ranging_light_switch_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Auto-ranging light switch. Each transfer on samples is a calibration read
// (action 0, loads the tracked maximum) or a light sample (action 1), and each
// gives exactly one transfer on results. A sample widens the tracked range,
// is scaled to a truncated percentage of it, and steps the two hold counters
// that switch the relay. The block takes one item at a time: a sample whose
// range is non-empty passes through the widen, scale, divide and decide
// states, the divide state waiting on the seven steps of the restoring
// divider; a zero range or an out-of-range case skips the divide state, and
// a calibration read goes from widen straight to decide. The next item is
// taken as soon as the result is registered, even if it has not yet been
// collected; an item that finishes while the previous result is still
// waiting holds until that result is collected. Configuration writes are
// taken in any cycle; a write of initial_min also presets the tracked minimum.

module auto_ranging_light_switch_core (
    input  wire          clk,
    input  wire          rst_n,
    arls_in_if.sink      samples,
    arls_out_if.source   results,
    arls_cfg_if.sink     cfg
);

    arls_pkg::state_t              state_reg;
    arls_pkg::state_t              state_next;
    logic                          action_reg;
    logic                          action_next;
    logic [arls_pkg::LEVEL_W-1:0]  sample_reg;
    logic [arls_pkg::LEVEL_W-1:0]  sample_next;
    logic [arls_pkg::LEVEL_W-1:0]  min_reg;
    logic [arls_pkg::LEVEL_W-1:0]  min_next;
    logic [arls_pkg::LEVEL_W-1:0]  max_reg;
    logic [arls_pkg::LEVEL_W-1:0]  max_next;
    logic [arls_pkg::HOLD_W-1:0]   under_reg;
    logic [arls_pkg::HOLD_W-1:0]   under_next;
    logic [arls_pkg::HOLD_W-1:0]   over_reg;
    logic [arls_pkg::HOLD_W-1:0]   over_next;
    logic                          relay_reg;
    logic                          relay_next;
    logic [arls_pkg::PCT_W-1:0]    thresh_reg;
    logic [arls_pkg::PCT_W-1:0]    thresh_next;
    logic [arls_pkg::HOLD_W-1:0]   hold_reg;
    logic [arls_pkg::HOLD_W-1:0]   hold_next;
    logic [arls_pkg::PCT_W-1:0]    pct_reg;
    logic [arls_pkg::PCT_W-1:0]    pct_next;
    logic                          zero_reg;
    logic                          zero_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_relay_reg;
    logic                          out_relay_next;
    logic [arls_pkg::PCT_W-1:0]    out_pct_reg;
    logic [arls_pkg::PCT_W-1:0]    out_pct_next;
    logic                          out_zero_reg;
    logic                          out_zero_next;

    arls_pkg::div_req_t            div_req;
    arls_pkg::div_rsp_t            div_rsp;

    logic [arls_pkg::LEVEL_W-1:0]  offset;
    logic [arls_pkg::LEVEL_W-1:0]  span;
    logic [arls_pkg::NUM_W-1:0]    scaled;
    logic                          dark;
    logic [arls_pkg::HOLD_W-1:0]   under_step;
    logic [arls_pkg::HOLD_W-1:0]   over_step;
    logic                          relay_step;

    arls_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign offset = sample_reg - min_reg;
    assign span   = max_reg - min_reg;
    assign scaled = arls_pkg::NUM_W'(offset) * arls_pkg::NUM_W'(arls_pkg::PERCENT_FULL);
    assign dark   = pct_reg < thresh_reg;

    always_comb
    begin
        under_step = under_reg;
        over_step  = over_reg;
        if (dark)
        begin
            if (under_reg != '0)
            begin
                under_step = under_reg - 1'b1;
            end
            if (over_reg < hold_reg)
            begin
                over_step = hold_reg;
            end
        end
        else
        begin
            if (over_reg != '0)
            begin
                over_step = over_reg - 1'b1;
            end
            if (under_reg < hold_reg)
            begin
                under_step = hold_reg;
            end
        end
        relay_step = relay_reg;
        if (under_step == '0)
        begin
            relay_step = 1'b1;
        end
        else if (over_step == '0)
        begin
            relay_step = 1'b0;
        end
    end

    assign samples.ready = (state_reg == arls_pkg::ST_IDLE);
    assign cfg.ready     = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        action_next    = action_reg;
        sample_next    = sample_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        under_next     = under_reg;
        over_next      = over_reg;
        relay_next     = relay_reg;
        thresh_next    = thresh_reg;
        hold_next      = hold_reg;
        pct_next       = pct_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        out_relay_next = out_relay_reg;
        out_pct_next   = out_pct_reg;
        out_zero_next  = out_zero_reg;
        div_req.start  = 1'b0;
        div_req.num    = scaled;
        div_req.den    = span;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            arls_pkg::ST_IDLE:
            begin
                if (samples.valid)
                begin
                    action_next = samples.action;
                    sample_next = arls_pkg::to_level(samples.sample);
                    state_next  = arls_pkg::ST_WIDEN;
                end
            end
            arls_pkg::ST_WIDEN:
            begin
                if (action_reg == arls_pkg::ACTION_CALIBRATE)
                begin
                    max_next   = sample_reg;
                    pct_next   = '0;
                    zero_next  = 1'b0;
                    state_next = arls_pkg::ST_DECIDE;
                end
                else
                begin
                    if (sample_reg < min_reg)
                    begin
                        min_next = sample_reg;
                    end
                    else if (sample_reg > max_reg)
                    begin
                        max_next = sample_reg;
                    end
                    state_next = arls_pkg::ST_SCALE;
                end
            end
            arls_pkg::ST_SCALE:
            begin
                pct_next  = '0;
                zero_next = 1'b0;
                if (max_reg == min_reg)
                begin
                    zero_next  = 1'b1;
                    state_next = arls_pkg::ST_DECIDE;
                end
                else if (max_reg > min_reg && sample_reg >= min_reg)
                begin
                    div_req.start = 1'b1;
                    state_next    = arls_pkg::ST_DIVIDE;
                end
                else
                begin
                    state_next = arls_pkg::ST_DECIDE;
                end
            end
            arls_pkg::ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient > arls_pkg::PERCENT_FULL)
                    begin
                        pct_next = arls_pkg::PERCENT_FULL;
                    end
                    else
                    begin
                        pct_next = div_rsp.quotient;
                    end
                    state_next = arls_pkg::ST_DECIDE;
                end
            end
            arls_pkg::ST_DECIDE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    if (action_reg != arls_pkg::ACTION_CALIBRATE)
                    begin
                        under_next     = under_step;
                        over_next      = over_step;
                        relay_next     = relay_step;
                        out_relay_next = relay_step;
                    end
                    else
                    begin
                        out_relay_next = relay_reg;
                    end
                    out_pct_next   = pct_reg;
                    out_zero_next  = zero_reg;
                    out_valid_next = 1'b1;
                    state_next     = arls_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = arls_pkg::ST_IDLE;
            end
        endcase

        if (cfg.valid)
        begin
            case (cfg.index)
                arls_pkg::REG_THRESHOLD:
                begin
                    thresh_next = cfg.data[arls_pkg::PCT_W-1:0];
                end
                arls_pkg::REG_HOLD:
                begin
                    hold_next = cfg.data[arls_pkg::HOLD_W-1:0];
                end
                arls_pkg::REG_INIT_MIN:
                begin
                    min_next = arls_pkg::to_level(cfg.data[arls_pkg::SAMPLE_W-1:0]);
                end
                default:
                begin
                    thresh_next = thresh_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arls_pkg::ST_IDLE;
            min_reg       <= arls_pkg::LEVEL_RESET;
            max_reg       <= arls_pkg::LEVEL_RESET;
            under_reg     <= '0;
            over_reg      <= '0;
            relay_reg     <= 1'b0;
            thresh_reg    <= arls_pkg::THRESHOLD_RESET;
            hold_reg      <= arls_pkg::HOLD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            under_reg     <= under_next;
            over_reg      <= over_next;
            relay_reg     <= relay_next;
            thresh_reg    <= thresh_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg    <= action_next;
        sample_reg    <= sample_next;
        pct_reg       <= pct_next;
        zero_reg      <= zero_next;
        out_relay_reg <= out_relay_next;
        out_pct_reg   <= out_pct_next;
        out_zero_reg  <= out_zero_next;
    end

    assign results.valid         = out_valid_reg;
    assign results.relay_on      = out_relay_reg;
    assign results.light_percent = out_pct_reg;
    assign results.range_zero    = out_zero_reg;

endmodule

`default_nettype wire
